[hdl/rsos_pkg.sv]
package rsos_pkg;

  localparam int SENSORS_DEF = 8;

  localparam int IDX_W     = 3;
  localparam int DIST_W    = 16;
  localparam int YAW_W     = 16;
  localparam int VEL_W     = 24;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // Proximity and gain are unsigned Q1.16 values that may reach exactly 1.0.
  localparam int PROX_W     = 17;
  localparam int DIV_CNT_W  = $clog2(PROX_W);
  localparam int MUL_A_W    = 24;
  localparam int MUL_B_W    = 17;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int EXT_W      = VEL_W + 2;

  localparam logic [0:0] OP_SAMPLE = 1'b0;
  localparam logic [0:0] OP_LOAD   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANG   = 2'd2;

  localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd500;
  localparam logic [CFG_W-1:0] MAX_LIN_RST   = 16'd256;
  localparam logic [CFG_W-1:0] MAX_ANG_RST   = 16'd256;

  localparam logic signed [VEL_W-1:0] VEL_ONE     = 24'sd65536;
  localparam logic signed [VEL_W-1:0] VEL_EPS     = 24'sd65;
  localparam logic signed [VEL_W-1:0] VEL_EPS_NEG = -24'sd65;
  localparam logic signed [VEL_W-1:0] VEL_MAX     = 24'sd8388607;
  localparam logic signed [VEL_W-1:0] VEL_MIN     = -24'sd8388608;
  localparam logic signed [EXT_W-1:0] EXT_ONE     = 26'sd65536;
  localparam logic signed [EXT_W-1:0] EXT_MAX     = 26'sd8388607;
  localparam logic signed [EXT_W-1:0] EXT_MIN     = -26'sd8388608;

  localparam logic [PROX_W-1:0] GAIN_ONE = 17'd65536;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_DIV     = 9'b000000010,
    ST_MUL_GP  = 9'b000000100,
    ST_MUL_CHG = 9'b000001000,
    ST_UPD_ANG = 9'b000010000,
    ST_UPD_LIN = 9'b000100000,
    ST_OUT_LIN = 9'b001000000,
    ST_OUT_ANG = 9'b010000000,
    ST_OUT_FIN = 9'b100000000
  } state_t;

  typedef struct packed {
    logic start;
    logic [DIST_W-1:0] diff;
    logic [DIST_W-1:0] divisor;
  } div_req_t;

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [EXT_W-1:0] v);
    logic signed [VEL_W-1:0] r;
    if (v > EXT_MAX) begin
      r = VEL_MAX;
    end else if (v < EXT_MIN) begin
      r = VEL_MIN;
    end else begin
      r = v[VEL_W-1:0];
    end
    return r;
  endfunction

  // Sign and magnitude of a scaled command back to a saturated two's complement value.
  function automatic logic [VEL_W-1:0] sat_cmd(input logic neg, input logic [32:0] mag);
    logic [VEL_W-1:0] r;
    if (neg) begin
      if (mag > 33'd8388608) begin
        r = VEL_MIN;
      end else begin
        r = VEL_W'(-mag);
      end
    end else begin
      if (mag > 33'd8388607) begin
        r = VEL_MAX;
      end else begin
        r = VEL_W'(mag);
      end
    end
    return r;
  endfunction

endpackage

[hdl/rsos_div.sv]
module rsos_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rsos_pkg::div_req_t            req,
  output logic [rsos_pkg::PROX_W-1:0]   quot,
  output logic                          done
);
  import rsos_pkg::*;

  logic [PROX_W-1:0]    rem_r;
  logic [PROX_W-1:0]    quot_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 first_r;
  logic                 done_r;
  logic [PROX_W-1:0]    trial;
  logic                 fits;

  // The dividend is (diff << 16) and diff never exceeds the divisor, so the
  // quotient has only 17 bits: one compare with no shift, then 16 shifted steps.
  always_comb begin
    trial = first_r ? rem_r : {rem_r[PROX_W-2:0], 1'b0};
    fits  = trial >= {1'b0, req.divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (req.start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
      end else if (busy_r && cnt_r == DIV_CNT_W'(PROX_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r   <= {1'b0, req.diff};
      quot_r  <= '0;
      cnt_r   <= '0;
      first_r <= 1'b1;
    end else if (busy_r) begin
      rem_r   <= fits ? trial - {1'b0, req.divisor} : trial;
      quot_r  <= {quot_r[PROX_W-2:0], fits};
      cnt_r   <= cnt_r + 1'b1;
      first_r <= 1'b0;
    end
  end

  assign quot = quot_r;
  assign done = done_r;

endmodule

[hdl/range_sensor_obstacle_steering_unit.sv]
// Channel  Direction  Signals                                        Contents
// in       input      in_tvalid/in_tready/in_tdata/in_tuser/in_tlast  sample or yaw load
// out      output     out_tvalid/out_tready/out_tdata                 velocity commands
// cfg      input      cfg_we/cfg_index/cfg_wdata                      threshold and speeds
//
// A yaw load, or a sample above the threshold that is not last, leaves the unit idle.
// A valid-index sample at or below the threshold runs the bit-serial divider (17 steps
// and a done pulse), then two multiplies and two update steps; with a zero threshold
// the divider is skipped. A last sample adds ST_OUT_LIN, ST_OUT_ANG and ST_OUT_FIN.
// rst_n is synchronous; it resets the sequencer, the sweep and the velocities.
// A result waits in the output register, and only the next result stalls behind it.
module range_sensor_obstacle_steering_unit #(
  parameter int SENSORS = rsos_pkg::SENSORS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // sensor_index [2:0], range_mm [18:3], mount_yaw [34:19], zero padding above
  input  logic [rsos_pkg::IN_DATA_W-1:0]     in_tdata,
  // opcode
  input  logic [0:0]                         in_tuser,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // linear_command [23:0], angular_command [47:24]
  output logic [rsos_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               cfg_we,
  input  logic [rsos_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rsos_pkg::CFG_W-1:0]         cfg_wdata
);
  import rsos_pkg::*;

  localparam int ADDR_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam logic [6:0] IDX_LIM = 7'(SENSORS);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] thr_r, max_lin_r, max_ang_r;
  logic             sweep_open_r;
  logic             last_r;
  logic             out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic signed [VEL_W-1:0] lin_r, ang_r;
  logic signed [YAW_W-1:0] yaw_rd_r;
  logic [PROX_W-1:0]       prox_r;
  logic [PROD_W-1:0]       prod_r;
  logic                    prod_neg_r;
  logic [VEL_W-1:0]        lin_cmd_r;

  logic signed [YAW_W-1:0] yaw_mem [SENSORS];

  logic [IDX_W-1:0]  in_idx;
  logic [DIST_W-1:0] in_range;
  logic [YAW_W-1:0]  in_yaw;
  logic              accept, is_load, idx_ok, hit, thr_zero;
  logic [ADDR_W-1:0] yaw_addr;

  div_req_t          div_req;
  logic [PROX_W-1:0] div_quot;
  logic              div_done;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;

  logic [PROX_W-1:0]       yaw_mag;
  logic signed [PROX_W-1:0] yaw_ext;
  logic [MUL_A_W-1:0]      lin_mag, ang_mag;
  logic signed [EXT_W-1:0] ang_ext, chg_mag, chg_ext, ang_upd;
  logic                    yaw_zero, ang_small, add_dir, out_free;

  assign in_idx   = in_tdata[2:0];
  assign in_range = in_tdata[18:3];
  assign in_yaw   = in_tdata[34:19];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign is_load   = (in_tuser == OP_LOAD);
  assign idx_ok    = ({4'b0, in_idx} < IDX_LIM);
  assign thr_zero  = (thr_r == '0);
  assign hit       = idx_ok && (in_range <= thr_r);
  assign yaw_addr  = ADDR_W'(in_idx);
  assign out_free  = !out_valid_r || out_tready;

  assign div_req.start   = accept && !is_load && hit && !thr_zero;
  assign div_req.diff    = thr_r - in_range;
  assign div_req.divisor = thr_r;

  rsos_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .quot (div_quot),
    .done (div_done)
  );

  always_comb begin
    yaw_ext   = {yaw_rd_r[YAW_W-1], yaw_rd_r};
    yaw_mag   = yaw_rd_r[YAW_W-1] ? PROX_W'(-yaw_ext) : PROX_W'(yaw_ext);
    lin_mag   = lin_r[VEL_W-1] ? MUL_A_W'(-lin_r) : MUL_A_W'(lin_r);
    ang_mag   = ang_r[VEL_W-1] ? MUL_A_W'(-ang_r) : MUL_A_W'(ang_r);
    ang_ext   = {{2{ang_r[VEL_W-1]}}, ang_r};
    chg_mag   = {2'b00, prod_r[39:16]};
    // The change carries the sign of the linear velocity.
    chg_ext   = lin_r[VEL_W-1] ? -chg_mag : chg_mag;
    yaw_zero  = (yaw_rd_r == '0);
    ang_small = (ang_r <= VEL_EPS) && (ang_r >= VEL_EPS_NEG);
    // Negative yaw adds the change; zero yaw adds it unless ang_r is negative.
    add_dir   = yaw_rd_r[YAW_W-1] || (yaw_zero && !ang_r[VEL_W-1]);
    ang_upd   = add_dir ? ang_ext + chg_ext : ang_ext - chg_ext;
  end

  // The shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL_GP: begin
        mul_a = MUL_A_W'(GAIN_ONE - yaw_mag);
        mul_b = prox_r;
      end
      ST_MUL_CHG: begin
        mul_a = lin_mag;
        mul_b = prod_r[32:16];
      end
      ST_OUT_LIN: begin
        mul_a = lin_mag;
        mul_b = {1'b0, max_lin_r};
      end
      ST_OUT_ANG: begin
        mul_a = ang_mag;
        mul_b = {1'b0, max_ang_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && !is_load) begin
          if (hit) begin
            state_nxt = thr_zero ? ST_MUL_GP : ST_DIV;
          end else if (in_tlast) begin
            state_nxt = ST_OUT_LIN;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_MUL_GP;
        end
      end
      ST_MUL_GP:  state_nxt = ST_MUL_CHG;
      ST_MUL_CHG: state_nxt = ST_UPD_ANG;
      ST_UPD_ANG: state_nxt = ST_UPD_LIN;
      ST_UPD_LIN: state_nxt = last_r ? ST_OUT_LIN : ST_IDLE;
      ST_OUT_LIN: state_nxt = ST_OUT_ANG;
      ST_OUT_ANG: state_nxt = ST_OUT_FIN;
      ST_OUT_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      thr_r        <= THRESHOLD_RST;
      max_lin_r    <= MAX_LIN_RST;
      max_ang_r    <= MAX_ANG_RST;
      sweep_open_r <= 1'b0;
      out_valid_r  <= 1'b0;
      lin_r        <= VEL_ONE;
      ang_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD: thr_r     <= cfg_wdata;
          CFG_MAX_LIN:   max_lin_r <= cfg_wdata;
          CFG_MAX_ANG:   max_ang_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept && !is_load) begin
        sweep_open_r <= !in_tlast;
        if (!sweep_open_r) begin
          lin_r <= VEL_ONE;
          ang_r <= '0;
        end
      end
      if (state_r == ST_UPD_ANG) begin
        ang_r <= (yaw_zero && ang_small) ? '0 : sat_vel(ang_upd);
      end
      if (state_r == ST_UPD_LIN) begin
        lin_r <= sat_vel(EXT_ONE - ang_ext);
      end
      if (state_r == ST_OUT_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers and the yaw table carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (is_load) begin
        if (idx_ok) begin
          yaw_mem[yaw_addr] <= in_yaw;
        end
      end else begin
        yaw_rd_r <= yaw_mem[yaw_addr];
        last_r   <= in_tlast;
        prox_r   <= '0;
      end
    end
    if (state_r == ST_DIV && div_done) begin
      prox_r <= div_quot;
    end
    case (state_r)
      ST_MUL_GP, ST_MUL_CHG: prod_r <= mul_p;
      ST_OUT_LIN: begin
        prod_r     <= mul_p;
        prod_neg_r <= lin_r[VEL_W-1];
      end
      ST_OUT_ANG: begin
        prod_r     <= mul_p;
        prod_neg_r <= ang_r[VEL_W-1];
        lin_cmd_r  <= sat_cmd(prod_neg_r, prod_r[40:8]);
      end
      default: ;
    endcase
    if (state_r == ST_OUT_FIN && out_free) begin
      out_data_r <= {sat_cmd(prod_neg_r, prod_r[40:8]), lin_cmd_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
